/* sv/ltpp_pkg.sv */
// Shared types and constants for the luma threshold page packer.
`timescale 1ns / 1ps

package ltpp_pkg;

  // Default frame geometry in pixels
  localparam int unsigned FRAME_WIDTH_DEF  = 128;
  localparam int unsigned FRAME_HEIGHT_DEF = 64;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // BT.601 luma weights, scaled by 256
  localparam logic [7:0] LUMA_COEF_R = 8'd77;
  localparam logic [7:0] LUMA_COEF_G = 8'd150;
  localparam logic [7:0] LUMA_COEF_B = 8'd29;

  // Threshold after reset
  localparam logic [7:0] THRESHOLD_RESET = 8'd128;

  // Field widths of the result item
  localparam int unsigned PAGE_W   = 3;
  localparam int unsigned COLUMN_W = 7;
  localparam int unsigned BYTE_W   = 8;

  // Row position within a page
  localparam int unsigned BITPOS_W = 3;

  // Classification of one pixel, handed from front to back
  typedef struct packed {
    logic [BITPOS_W-1:0] bitpos;      // row within the page
    logic                lit;         // luma above threshold
    logic                emit;        // this pixel completes a page byte
    logic                frame_done;  // last byte of the frame
    logic [PAGE_W-1:0]   page;        // page of the byte
  } item_ctl_t;

  localparam int unsigned ITEM_CTL_W = $bits(item_ctl_t);

endpackage

/* sv/ltpp_if.sv */
// Handshake channels of the luma threshold page packer.
`timescale 1ns / 1ps

// Pixel input channel
interface ltpp_pixel_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_color;

  modport source (output valid, output pixel_color, input ready);
  modport sink (input valid, input pixel_color, output ready);
endinterface

// Page byte result channel
interface ltpp_result_if;
  logic                            valid;
  logic                            ready;
  logic [ltpp_pkg::PAGE_W-1:0]     page_index;
  logic [ltpp_pkg::COLUMN_W-1:0]   column_index;
  logic [ltpp_pkg::BYTE_W-1:0]     page_byte;
  logic                            frame_done;

  modport source (output valid, output page_index, output column_index,
                  output page_byte, output frame_done, input ready);
  modport sink (input valid, input page_index, input column_index,
                input page_byte, input frame_done, output ready);
endinterface

// Threshold register write channel
interface ltpp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_threshold;

  modport source (output valid, output luma_threshold, input ready);
  modport sink (input valid, input luma_threshold, output ready);
endinterface

/* sv/ltpp_front.sv */
// Front end: takes pixels, forms luma, thresholds and tracks raster position.
`timescale 1ns / 1ps

module ltpp_front #(
  parameter int unsigned FRAME_WIDTH  = ltpp_pkg::FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = ltpp_pkg::FRAME_HEIGHT_DEF,
  localparam int unsigned ColW = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1,
  localparam int unsigned RowW = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ltpp_pixel_if.sink          pix_i,
  ltpp_cfg_if.sink            cfg_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output logic [ColW-1:0]     q_col_o,
  output ltpp_pkg::item_ctl_t q_ctl_o
);

  localparam logic [ColW-1:0] LastCol = ColW'(FRAME_WIDTH - 1);
  localparam logic [RowW-1:0] LastRow = RowW'(FRAME_HEIGHT - 1);

  logic [7:0]      thresh_q;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            fire;
  logic            last_col, last_row;
  logic [15:0]     prod_r, prod_g, prod_b, luma_sum;
  logic [7:0]      luma;

  // Threshold register, always writable
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ltpp_pkg::THRESHOLD_RESET;
    end else if (cfg_i.valid) begin
      thresh_q <= cfg_i.luma_threshold;
    end
  end

  // Luma: weighted sum scaled by 256, top byte kept
  assign prod_r   = {8'd0, pix_i.pixel_color[23:16]} * {8'd0, ltpp_pkg::LUMA_COEF_R};
  assign prod_g   = {8'd0, pix_i.pixel_color[15:8]} * {8'd0, ltpp_pkg::LUMA_COEF_G};
  assign prod_b   = {8'd0, pix_i.pixel_color[7:0]} * {8'd0, ltpp_pkg::LUMA_COEF_B};
  assign luma_sum = prod_r + prod_g + prod_b;
  assign luma     = luma_sum[15:8];

  // Handshake: an item enters whenever the queue has room
  assign pix_i.ready = q_ready_i;
  assign q_valid_o   = pix_i.valid;
  assign fire        = pix_i.valid && q_ready_i;

  assign last_col = (col_q == LastCol);
  assign last_row = (row_q == LastRow);

  // Classification of the current pixel
  always_comb begin
    q_col_o            = col_q;
    q_ctl_o.bitpos     = row_q[ltpp_pkg::BITPOS_W-1:0];
    q_ctl_o.lit        = (luma > thresh_q);
    q_ctl_o.emit       = (row_q[ltpp_pkg::BITPOS_W-1:0] == 3'd7) || last_row;
    q_ctl_o.frame_done = last_row && last_col;
    q_ctl_o.page       = ltpp_pkg::PAGE_W'(row_q >> ltpp_pkg::BITPOS_W);
  end

  // Raster position counters
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (fire) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

/* sv/ltpp_queue.sv */
// Short FIFO between the front and back ends.
`timescale 1ns / 1ps

module ltpp_queue #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = ltpp_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);

  logic [DATA_W-1:0] slot_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* sv/ltpp_back.sv */
// Back end: column accumulator memory and result register.
`timescale 1ns / 1ps

module ltpp_back #(
  parameter int unsigned FRAME_WIDTH = ltpp_pkg::FRAME_WIDTH_DEF,
  localparam int unsigned ColW = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_ready_o,
  input  logic [ColW-1:0]     q_col_i,
  input  ltpp_pkg::item_ctl_t q_ctl_i,
  ltpp_result_if.source       res_o
);

  logic [ltpp_pkg::BYTE_W-1:0] col_mem [FRAME_WIDTH];

  // Read stage: item plus the accumulator entry read for it
  logic                        s1_valid_q;
  logic [ColW-1:0]             s1_col_q;
  ltpp_pkg::item_ctl_t         s1_ctl_q;
  logic [ltpp_pkg::BYTE_W-1:0] rdata_q;

  // Result register
  logic                          out_valid_q;
  logic [ltpp_pkg::PAGE_W-1:0]   out_page_q;
  logic [ltpp_pkg::COLUMN_W-1:0] out_col_q;
  logic [ltpp_pkg::BYTE_W-1:0]   out_byte_q;
  logic                          out_done_q;

  logic                        out_free, s1_adv, s1_load;
  logic [ltpp_pkg::BYTE_W-1:0] cur_byte;

  // Stage control: the read stage moves on unless its byte has nowhere to go
  assign out_free  = !out_valid_q || res_o.ready;
  assign s1_adv    = s1_valid_q && (!s1_ctl_q.emit || out_free);
  assign s1_load   = q_valid_i && q_ready_o;
  assign q_ready_o = !s1_valid_q || s1_adv;

  // Merge the new bit; the first row of a page starts the byte afresh
  always_comb begin
    if (s1_ctl_q.bitpos == '0) begin
      cur_byte = {{(ltpp_pkg::BYTE_W-1){1'b0}}, s1_ctl_q.lit};
    end else begin
      cur_byte = rdata_q | (ltpp_pkg::BYTE_W'(s1_ctl_q.lit) << s1_ctl_q.bitpos);
    end
  end

  // Accumulator memory; consecutive items hit different columns whenever FRAME_WIDTH is above one
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      col_mem[s1_col_q] <= cur_byte;
    end
    if (s1_load) begin
      rdata_q <= col_mem[q_col_i];
    end
  end

  // Read stage payload
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_col_q <= q_col_i;
      s1_ctl_q <= q_ctl_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (q_ready_o) begin
      s1_valid_q <= q_valid_i;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_ctl_q.emit) begin
      out_page_q <= s1_ctl_q.page;
      out_col_q  <= ltpp_pkg::COLUMN_W'(s1_col_q);
      out_byte_q <= cur_byte;
      out_done_q <= s1_ctl_q.frame_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_adv && s1_ctl_q.emit;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.page_index   = out_page_q;
  assign res_o.column_index = out_col_q;
  assign res_o.page_byte    = out_byte_q;
  assign res_o.frame_done   = out_done_q;

endmodule

/* sv/luma_threshold_page_packer_unit.sv */
// Top level of the luma threshold page packer.
//
//   channel  dir  handshake      payload
//   pix_i    in   valid / ready  pixel_color[23:0]
//   cfg_i    in   valid / ready  luma_threshold[7:0], ready always high
//   res_o    out  valid / ready  page_index, column_index, page_byte, frame_done
//
// One pixel per clock is sustained while res_o is ready; a completing pixel's byte
// passes through the queue, the accumulator read stage and the result register
// before it is valid on res_o, where it is held until it is taken.
// rst_ni clears counters, queue and stage valids; threshold returns to 128.
// The accumulator memory needs no clearing: each page's first row overwrites it.
// A stalled result holds the back end; the queue then fills and drops pix_i.ready.
`timescale 1ns / 1ps

module luma_threshold_page_packer_unit #(
  parameter int unsigned FRAME_WIDTH  = ltpp_pkg::FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = ltpp_pkg::FRAME_HEIGHT_DEF,
  parameter int unsigned QUEUE_DEPTH  = ltpp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ltpp_pixel_if.sink    pix_i,
  ltpp_cfg_if.sink      cfg_i,
  ltpp_result_if.source res_o
);

  localparam int unsigned ColW  = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int unsigned ItemW = ColW + ltpp_pkg::ITEM_CTL_W;

  logic                front_valid, front_ready;
  logic [ColW-1:0]     front_col;
  ltpp_pkg::item_ctl_t front_ctl;
  logic                back_valid, back_ready;
  logic [ColW-1:0]     back_col;
  ltpp_pkg::item_ctl_t back_ctl;
  logic [ItemW-1:0]    push_data, pop_data;

  // Front end
  ltpp_front #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix_i),
    .cfg_i     (cfg_i),
    .q_valid_o (front_valid),
    .q_ready_i (front_ready),
    .q_col_o   (front_col),
    .q_ctl_o   (front_ctl)
  );

  // Queue between the two ends
  assign push_data = {front_col, front_ctl};
  assign back_col  = pop_data[ItemW-1:ltpp_pkg::ITEM_CTL_W];
  assign back_ctl  = ltpp_pkg::item_ctl_t'(pop_data[ltpp_pkg::ITEM_CTL_W-1:0]);

  ltpp_queue #(
    .DATA_W (ItemW),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (pop_data)
  );

  // Back end
  ltpp_back #(
    .FRAME_WIDTH (FRAME_WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (back_valid),
    .q_ready_o (back_ready),
    .q_col_i   (back_col),
    .q_ctl_i   (back_ctl),
    .res_o     (res_o)
  );

endmodule
